>>> sv/rbsd_pkg.sv
package rbsd_pkg;

  // Decoder phases of the front part.
  typedef enum logic [2:0] {
    PH_SKIP,
    PH_OPCODE,
    PH_LENGTH,
    PH_VALUE,
    PH_LITERAL
  } phase_t;

  // Result status codes.
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_CLEAN = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_SKIP  = 2'd3;

  // Opcodes and fixed byte values.
  localparam logic [7:0] OP_ZERO_RUN = 8'h00;
  localparam logic [7:0] OP_LIT_MIN  = 8'h01;
  localparam logic [7:0] OP_LIT_MAX  = 8'h7F;
  localparam logic [7:0] OP_LEN1     = 8'h80;
  localparam logic [7:0] OP_LEN2     = 8'h81;
  localparam logic [7:0] OP_SPACES   = 8'h82;
  localparam logic [7:0] OP_REP_BASE = 8'h80;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam logic [7:0] ZERO_CHAR   = 8'h00;

  // What follows a gathered length.
  localparam logic [1:0] FILL_ZERO  = 2'd0;
  localparam logic [1:0] FILL_VALUE = 2'd1;
  localparam logic [1:0] FILL_SPACE = 2'd2;

  // Length bytes still due.
  localparam logic [1:0] LB_NONE = 2'd0;
  localparam logic [1:0] LB_ONE  = 2'd1;
  localparam logic [1:0] LB_TWO  = 2'd2;
  localparam logic [1:0] LB_HIGH = 2'd3;

  localparam int QUEUE_DEPTH_DEF = 4;

  // One queue entry: the results that one accepted byte causes.
  typedef struct packed {
    logic        has_run;
    logic [7:0]  value;
    logic [15:0] count;
    logic        has_st;
    logic [1:0]  st;
  } entry_t;

endpackage

>>> sv/rbsd_front.sv
module rbsd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // in_byte
  input  logic                  in_tlast,   // stream_end
  input  logic                  q_full,
  output logic                  q_push,
  output rbsd_pkg::entry_t      q_entry
);

  rbsd_pkg::phase_t phase_r, phase_dec, phase_nxt;
  logic [31:0] skip_bytes_r, skip_bytes_nxt;
  logic [31:0] skip_left_r, skip_left_dec, skip_left_nxt;
  logic [6:0]  lit_left_r, lit_left_dec, lit_left_nxt;
  logic [15:0] acc_r, acc_dec, acc_nxt;
  logic [1:0]  lbl_r, lbl_dec, lbl_nxt;
  logic [1:0]  fill_r, fill_dec, fill_nxt;
  logic        stopped_r, stopped_dec, stopped_nxt;

  logic        accept;
  logic [15:0] len_full;
  logic        run_has;
  logic [7:0]  run_val;
  logic [15:0] run_cnt;
  logic [1:0]  st;
  logic        restart;
  logic [31:0] restart_skip;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Length once its last byte has arrived.
  assign len_full = (lbl_r == rbsd_pkg::LB_HIGH) ? (acc_r | {in_tdata, 8'h00})
                                                 : {8'h00, in_tdata};

  // Next state as decoded from the current byte.
  always_comb begin
    phase_dec     = phase_r;
    skip_left_dec = skip_left_r;
    lit_left_dec  = lit_left_r;
    acc_dec       = acc_r;
    lbl_dec       = lbl_r;
    fill_dec      = fill_r;
    stopped_dec   = stopped_r;
    if (!stopped_r) begin
      unique case (phase_r)
        rbsd_pkg::PH_SKIP: begin
          skip_left_dec = skip_left_r - 32'd1;
          if (skip_left_r == 32'd1) phase_dec = rbsd_pkg::PH_OPCODE;
        end
        rbsd_pkg::PH_OPCODE: begin
          unique case (in_tdata) inside
            rbsd_pkg::OP_ZERO_RUN, rbsd_pkg::OP_LEN1,
            rbsd_pkg::OP_LEN2, rbsd_pkg::OP_SPACES: begin
              acc_dec   = '0;
              lbl_dec   = (in_tdata == rbsd_pkg::OP_LEN2) ? rbsd_pkg::LB_TWO
                                                          : rbsd_pkg::LB_ONE;
              fill_dec  = (in_tdata == rbsd_pkg::OP_ZERO_RUN) ? rbsd_pkg::FILL_ZERO :
                          (in_tdata == rbsd_pkg::OP_SPACES)   ? rbsd_pkg::FILL_SPACE :
                                                                rbsd_pkg::FILL_VALUE;
              phase_dec = rbsd_pkg::PH_LENGTH;
            end
            [rbsd_pkg::OP_LIT_MIN : rbsd_pkg::OP_LIT_MAX]: begin
              lit_left_dec = in_tdata[6:0];
              phase_dec    = rbsd_pkg::PH_LITERAL;
            end
            default: begin
              acc_dec   = {8'h00, in_tdata - rbsd_pkg::OP_REP_BASE};
              phase_dec = rbsd_pkg::PH_VALUE;
            end
          endcase
        end
        rbsd_pkg::PH_LENGTH: begin
          if (lbl_r == rbsd_pkg::LB_TWO) begin
            acc_dec = {8'h00, in_tdata};
            lbl_dec = rbsd_pkg::LB_HIGH;
          end else begin
            acc_dec = len_full;
            lbl_dec = rbsd_pkg::LB_NONE;
            if (fill_r == rbsd_pkg::FILL_VALUE) begin
              phase_dec = rbsd_pkg::PH_VALUE;
            end else begin
              phase_dec = rbsd_pkg::PH_OPCODE;
              if (fill_r == rbsd_pkg::FILL_ZERO && len_full == 16'd0) stopped_dec = 1'b1;
            end
          end
        end
        rbsd_pkg::PH_VALUE: begin
          phase_dec = rbsd_pkg::PH_OPCODE;
        end
        rbsd_pkg::PH_LITERAL: begin
          lit_left_dec = lit_left_r - 7'd1;
          if (lit_left_r == 7'd1) phase_dec = rbsd_pkg::PH_OPCODE;
        end
        default: begin
          phase_dec = rbsd_pkg::PH_OPCODE;
        end
      endcase
    end
  end

  // Results that the current byte causes.
  always_comb begin
    run_has = 1'b0;
    run_val = rbsd_pkg::ZERO_CHAR;
    run_cnt = '0;
    if (!stopped_r) begin
      unique case (phase_r)
        rbsd_pkg::PH_LENGTH: begin
          if (lbl_r != rbsd_pkg::LB_TWO && fill_r != rbsd_pkg::FILL_VALUE) begin
            run_has = (len_full != 16'd0);
            run_val = (fill_r == rbsd_pkg::FILL_SPACE) ? rbsd_pkg::SPACE_CHAR
                                                       : rbsd_pkg::ZERO_CHAR;
            run_cnt = len_full;
          end
        end
        rbsd_pkg::PH_VALUE: begin
          run_has = (acc_r != 16'd0);
          run_val = in_tdata;
          run_cnt = acc_r;
        end
        rbsd_pkg::PH_LITERAL: begin
          run_has = 1'b1;
          run_val = in_tdata;
          run_cnt = 16'd1;
        end
        default: begin
          run_has = 1'b0;
        end
      endcase
    end
    if (stopped_dec || phase_dec == rbsd_pkg::PH_OPCODE) st = rbsd_pkg::ST_CLEAN;
    else if (phase_dec == rbsd_pkg::PH_SKIP)              st = rbsd_pkg::ST_SKIP;
    else                                                   st = rbsd_pkg::ST_TRUNC;
  end

  assign q_push          = accept && (run_has || in_tlast);
  assign q_entry.has_run = run_has;
  assign q_entry.value   = run_val;
  assign q_entry.count   = run_cnt;
  assign q_entry.has_st  = in_tlast;
  assign q_entry.st      = st;

  // A register write or the end of a stream starts the decoder afresh.
  assign restart      = cfg_we || (accept && in_tlast);
  assign restart_skip = cfg_we ? cfg_wdata : skip_bytes_r;

  always_comb begin
    skip_bytes_nxt = cfg_we ? cfg_wdata : skip_bytes_r;
    phase_nxt      = phase_r;
    skip_left_nxt  = skip_left_r;
    lit_left_nxt   = lit_left_r;
    acc_nxt        = acc_r;
    lbl_nxt        = lbl_r;
    fill_nxt       = fill_r;
    stopped_nxt    = stopped_r;
    if (restart) begin
      phase_nxt     = (restart_skip != 32'd0) ? rbsd_pkg::PH_SKIP : rbsd_pkg::PH_OPCODE;
      skip_left_nxt = restart_skip;
      lit_left_nxt  = '0;
      acc_nxt       = '0;
      lbl_nxt       = rbsd_pkg::LB_NONE;
      fill_nxt      = rbsd_pkg::FILL_ZERO;
      stopped_nxt   = 1'b0;
    end else if (accept) begin
      phase_nxt     = phase_dec;
      skip_left_nxt = skip_left_dec;
      lit_left_nxt  = lit_left_dec;
      acc_nxt       = acc_dec;
      lbl_nxt       = lbl_dec;
      fill_nxt      = fill_dec;
      stopped_nxt   = stopped_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_bytes_r <= '0;
      phase_r      <= rbsd_pkg::PH_OPCODE;
      skip_left_r  <= '0;
      lit_left_r   <= '0;
      acc_r        <= '0;
      lbl_r        <= rbsd_pkg::LB_NONE;
      fill_r       <= rbsd_pkg::FILL_ZERO;
      stopped_r    <= 1'b0;
    end else begin
      skip_bytes_r <= skip_bytes_nxt;
      phase_r      <= phase_nxt;
      skip_left_r  <= skip_left_nxt;
      lit_left_r   <= lit_left_nxt;
      acc_r        <= acc_nxt;
      lbl_r        <= lbl_nxt;
      fill_r       <= fill_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

`ifndef SYNTHESIS
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rbsd_pkg::PH_SKIP |-> skip_left_r != 32'd0)
    else $error("skip phase with nothing left to skip");
  a_stopped_phase: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> phase_r == rbsd_pkg::PH_OPCODE)
    else $error("decoder stopped outside opcode wait");
  a_literal_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rbsd_pkg::PH_LITERAL |-> lit_left_r != 7'd0)
    else $error("literal phase with no literals due");
`endif

endmodule

>>> sv/rbsd_queue.sv
module rbsd_queue #(
  parameter int DEPTH = rbsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rbsd_pkg::entry_t push_entry,
  input  logic             pop,
  output rbsd_pkg::entry_t head,
  output logic             not_empty,
  output logic             full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rbsd_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == CW'(DEPTH));
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push)   wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop) rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    count_nxt = count_r + CW'(push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_entry.has_run || push_entry.has_st))
    else $error("queue entry carries no result");
`endif

endmodule

>>> sv/rbsd_back.sv
module rbsd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  rbsd_pkg::entry_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata,  // run_value, run_count
  output logic [1:0]       out_tuser,  // status
  output logic             out_tlast   // last_result
);

  logic        valid_r, valid_nxt;
  logic        half_r, half_nxt;
  logic [7:0]  value_r, value_nxt;
  logic [15:0] count_r, count_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        last_r, last_nxt;
  logic        load;

  assign load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    half_nxt  = half_r;
    value_nxt = value_r;
    count_nxt = count_r;
    st_nxt    = st_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        if (head.has_run && !half_r) begin
          value_nxt = head.value;
          count_nxt = head.count;
          st_nxt    = rbsd_pkg::ST_RUN;
          last_nxt  = !head.has_st;
          half_nxt  = head.has_st;
          pop       = !head.has_st;
        end else begin
          value_nxt = rbsd_pkg::ZERO_CHAR;
          count_nxt = '0;
          st_nxt    = head.st;
          last_nxt  = 1'b1;
          half_nxt  = 1'b0;
          pop       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    count_r <= count_nxt;
    st_r    <= st_nxt;
    last_r  <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {count_r, value_r};
  assign out_tuser  = st_r;
  assign out_tlast  = last_r;

`ifndef SYNTHESIS
  a_half_shown: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> valid_r && st_r == rbsd_pkg::ST_RUN && !last_r)
    else $error("split entry without its run on the output");
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && st_r != rbsd_pkg::ST_RUN |-> last_r)
    else $error("status result not marked last");
  a_half_head: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> head_valid && head.has_st)
    else $error("split entry left the queue early");
`endif

endmodule

>>> sv/rle_byte_stream_decoder.sv
// Run-length byte stream decoder. Compressed bytes arrive one per transaction on the in_
// channel (in_tlast marks the final byte of a stream); after skipping the number of leading
// bytes held in the skip register, the decoder reads opcodes and hands out runs as
// (value, count) pairs on the out_ channel, never expanding them, and gives a status result
// on the last byte of each stream. A byte is taken every clock cycle as long as the result
// queue has room: the front decoder updates its small state machine once for each byte,
// so the input rate is one byte per cycle. The output stage delivers one result per cycle
// while the consumer is ready, so a byte that causes both a run and a status result gives
// two results; the queue (QUEUE_DEPTH entries) absorbs these and consumer stalls.
// Writing the skip register restarts the decoder as at the start of a new stream; it must
// only be written while the block is idle. There is no clearing pass after reset.
module rle_byte_stream_decoder #(
  // Entries in the queue between decoder and output stage; at least 2.
  parameter int QUEUE_DEPTH = rbsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: skip_bytes register.
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // Compressed input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // in_byte
  input  logic        in_tlast,    // stream_end
  // Decoded results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // run_value [7:0], run_count [23:8]
  output logic [1:0]  out_tuser,   // status
  output logic        out_tlast    // last_result
);

  // Each queue entry holds every result that one input byte causes: an optional run
  // and, on the final byte of a stream, a status.
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_not_empty;
  rbsd_pkg::entry_t q_in;
  rbsd_pkg::entry_t q_head;

  // Front: accepts bytes, tracks the skip and the token in progress, and classifies
  // each byte into the results it gives.
  rbsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  rbsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .not_empty  (q_not_empty),
    .full       (q_full)
  );

  // Back: splits each entry into single result transactions held in an output register.
  rbsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_not_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> tb/sv/tb_rle_byte_stream_decoder.sv
`timescale 1ns / 100ps

module tb_rle_byte_stream_decoder;

  import rbsd_pkg::*;

  // Clock period is 10 ns; the run is abandoned if it has not ended by this cycle count.
  localparam int CYCLE_LIMIT  = 200000;
  // Cycles allowed for bytes that are still inside the decoder but cause no result.
  localparam int QUIET_CYCLES = 16;
  localparam logic [7:0] REP_MIN = OP_SPACES + 8'd1;
  localparam logic [7:0] REP_MAX = 8'hFF;

  // Opening stream, one transaction per entry: {stream_end, byte}.
  localparam logic [8:0] DIRECTED_SEQ [25] = '{
    {1'b0, OP_ZERO_RUN}, 9'h005,                           // zero run of 5
    {1'b0, OP_LIT_MIN},  9'h0FF,                           // single literal 0xFF
    {1'b0, OP_LEN1},     9'h000, 9'h041,                   // length 0: no run
    {1'b0, OP_LEN2},     9'h0FF, 9'h0FF, 9'h0AA,           // longest two-byte run
    {1'b0, OP_SPACES},   9'h003,                           // three spaces
    {1'b0, REP_MAX},     9'h055,                           // longest short repeat
    {1'b0, REP_MIN},     9'h100,                           // run, then clean end
    {1'b0, OP_SPACES},   9'h000,                           // zero spaces: no run
    {1'b0, OP_ZERO_RUN}, 9'h000,                           // end marker
    {1'b1, OP_LIT_MAX},                                    // ignored, clean end
    {1'b0, OP_LEN2},     9'h110,                           // truncated length
    {1'b1, OP_LIT_MAX}                                     // truncated literal block
  };

  // Configuration phases of the random part and their byte budgets.
  localparam logic [31:0] SKIP_PLAN   [6] = '{32'd0, 32'd3, 32'd1, 32'hFFFF_FFFF, 32'd5, 32'd0};
  localparam int          BUDGET_PLAN [6] = '{350, 200, 150, 50, 150, 150};

  typedef struct {
    logic [7:0]  value;
    logic [15:0] count;
    logic [1:0]  status;
    logic        last_flag;
  } run_result_t;

  // Keeps its own copy of the decoder state, works out the runs that each accepted byte
  // causes, and compares what comes out of the block against them in order.
  class rle_scoreboard;
    run_result_t expected_runs[$];
    int          errors;
    logic [31:0] skip_cfg;
    phase_t      phase;
    logic [6:0]  literals_due;
    logic [15:0] length_acc;
    logic [1:0]  length_due;
    logic [1:0]  fill_kind;
    logic [31:0] skip_due;
    bit          stopped;

    function new();
      errors   = 0;
      skip_cfg = '0;
      restart();
    endfunction

    function void restart();
      skip_due     = skip_cfg;
      phase        = (skip_due != 0) ? PH_SKIP : PH_OPCODE;
      literals_due = '0;
      length_acc   = '0;
      length_due   = LB_NONE;
      fill_kind    = FILL_ZERO;
      stopped      = 1'b0;
    endfunction

    function void configure(logic [31:0] skip);
      skip_cfg = skip;
      restart();
    endfunction

    function void push_result(logic [7:0] value, logic [15:0] count, logic [1:0] status);
      run_result_t r;
      r.value     = value;
      r.count     = count;
      r.status    = status;
      r.last_flag = 1'b0;
      expected_runs.push_back(r);
    endfunction

    function void push_run(logic [7:0] value, logic [15:0] count);
      if (count != 0) push_result(value, count, ST_RUN);
    endfunction

    function void note_byte(logic [7:0] b, logic stream_end);
      int base;
      base = expected_runs.size();
      if (!stopped) begin
        case (phase)
          PH_SKIP: begin
            skip_due = skip_due - 1;
            if (skip_due == 0) phase = PH_OPCODE;
          end
          PH_OPCODE: begin
            if (b == OP_ZERO_RUN || b == OP_LEN1 || b == OP_LEN2 || b == OP_SPACES) begin
              length_acc = '0;
              length_due = (b == OP_LEN2) ? LB_TWO : LB_ONE;
              fill_kind  = (b == OP_ZERO_RUN) ? FILL_ZERO :
                           (b == OP_SPACES) ? FILL_SPACE : FILL_VALUE;
              phase      = PH_LENGTH;
            end else if (b <= OP_LIT_MAX) begin
              literals_due = b[6:0];
              phase        = PH_LITERAL;
            end else begin
              length_acc = {8'h00, b - OP_REP_BASE};
              phase      = PH_VALUE;
            end
          end
          PH_LENGTH: begin
            if (length_due == LB_TWO) begin
              length_acc = {8'h00, b};
              length_due = LB_HIGH;
            end else begin
              if (length_due == LB_HIGH) length_acc[15:8] = b;
              else length_acc = {8'h00, b};
              length_due = LB_NONE;
              if (fill_kind == FILL_VALUE) begin
                phase = PH_VALUE;
              end else if (fill_kind == FILL_ZERO && length_acc == 0) begin
                stopped = 1'b1;
                phase   = PH_OPCODE;
              end else begin
                push_run((fill_kind == FILL_SPACE) ? SPACE_CHAR : ZERO_CHAR, length_acc);
                phase = PH_OPCODE;
              end
            end
          end
          PH_VALUE: begin
            push_run(b, length_acc);
            phase = PH_OPCODE;
          end
          PH_LITERAL: begin
            push_run(b, 16'd1);
            literals_due = literals_due - 7'd1;
            if (literals_due == 0) phase = PH_OPCODE;
          end
          default: phase = PH_OPCODE;
        endcase
      end
      if (stream_end) begin
        if (stopped || phase == PH_OPCODE) push_result('0, '0, ST_CLEAN);
        else if (phase == PH_SKIP) push_result('0, '0, ST_SKIP);
        else push_result('0, '0, ST_TRUNC);
        restart();
      end
      if (expected_runs.size() > base) expected_runs[expected_runs.size() - 1].last_flag = 1'b1;
    endfunction

    function void check_result(logic [7:0] value, logic [15:0] count, logic [1:0] status,
                               logic last_flag);
      run_result_t exp;
      if (expected_runs.size() == 0) begin
        $error("unexpected result: run_value %0h run_count %0d status %0d last_result %0b",
               value, count, status, last_flag);
        errors++;
        return;
      end
      exp = expected_runs.pop_front();
      if (value !== exp.value) begin
        $error("run_value: expected %0h, actual %0h", exp.value, value);
        errors++;
      end
      if (count !== exp.count) begin
        $error("run_count: expected %0d, actual %0d", exp.count, count);
        errors++;
      end
      if (status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, status);
        errors++;
      end
      if (last_flag !== exp.last_flag) begin
        $error("last_result: expected %0b, actual %0b", exp.last_flag, last_flag);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  rle_scoreboard runs_sb = new();

  // When low, neither side of the block idles: this gives a stretch of back-to-back traffic.
  bit          idle_on = 1'b1;
  int          bytes_sent = 0;
  int          cycle_count = 0;
  logic [7:0]  stream_q[$];
  logic [23:0] got_data;
  logic [1:0]  got_status;
  logic        got_last;

  rle_byte_stream_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Watchdog: a run that hangs on a handshake ends here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The consumer stalls in roughly one cycle out of ten, except during the back-to-back stretch.
  always @(negedge clk) begin
    out_tready <= !idle_on || ($urandom_range(0, 99) >= 10);
  end

  // Result monitor. Outputs are captured at the rising edge; the comparison is pushed a
  // little later in the same cycle so that a byte accepted at the very same edge has
  // already been noted by the input driver, whatever order the simulator picks.
  always @(posedge clk) begin
    if (out_tvalid === 1'b1 && out_tready) begin
      got_data   = out_tdata;
      got_status = out_tuser;
      got_last   = out_tlast;
      #1;
      runs_sb.check_result(got_data[7:0], got_data[23:8], got_status, got_last);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one byte as an input transaction, with random idle cycles before it, and notes
  // it in the scoreboard at the edge where it is taken. Returns at the following falling edge.
  task automatic send_byte(input logic [7:0] b, input logic stream_end);
    idle_on = !(bytes_sent >= 500 && bytes_sent < 700);
    while (idle_on && $urandom_range(0, 99) < 10) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = stream_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    runs_sb.note_byte(b, stream_end);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Waits until every expected result has come out and the decoder has had time to take in
  // bytes that cause none; the block is then idle and the register may be written.
  task automatic drain();
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
    while (runs_sb.expected_runs.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_skip(input logic [31:0] skip);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = skip;
    @(posedge clk);
    runs_sb.configure(skip);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Appends one well-formed token with random content. Literal blocks are mostly short,
  // with the odd long one; zero lengths turn up now and then, except after OP_ZERO_RUN.
  task automatic add_token();
    int          kind;
    int          n;
    logic [15:0] len;
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        stream_q.push_back(OP_ZERO_RUN);
        stream_q.push_back(8'($urandom_range(1, 255)));
      end
      1, 2: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(OP_LIT_MIN, OP_LIT_MAX)
                                         : $urandom_range(1, 6);
        stream_q.push_back(8'(n));
        repeat (n) stream_q.push_back(rand_byte());
      end
      3: begin
        stream_q.push_back(OP_LEN1);
        stream_q.push_back(($urandom_range(0, 7) == 0) ? 8'h00 : rand_byte());
        stream_q.push_back(rand_byte());
      end
      4: begin
        len = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
        stream_q.push_back(OP_LEN2);
        stream_q.push_back(len[7:0]);
        stream_q.push_back(len[15:8]);
        stream_q.push_back(rand_byte());
      end
      5: begin
        stream_q.push_back(OP_SPACES);
        stream_q.push_back(($urandom_range(0, 7) == 0) ? 8'h00 : rand_byte());
      end
      default: begin
        stream_q.push_back(8'($urandom_range(REP_MIN, REP_MAX)));
        stream_q.push_back(rand_byte());
      end
    endcase
  endtask

  // Builds one stream in stream_q. Most streams are the skipped prefix followed by a few
  // tokens and end cleanly; some finish on an end marker with trailing bytes, some are cut
  // short at a random byte, and a few are plain noise.
  task automatic build_stream(input logic [31:0] skip);
    int mode;
    int cut;
    stream_q.delete();
    mode = $urandom_range(0, 99);
    if (skip > 32'd64 || mode < 8) begin
      repeat ($urandom_range(1, 12)) stream_q.push_back(rand_byte());
      return;
    end
    repeat (skip) stream_q.push_back(rand_byte());
    repeat ($urandom_range(1, 6)) add_token();
    if (mode < 20) begin
      stream_q.push_back(OP_ZERO_RUN);
      stream_q.push_back(8'h00);
      repeat ($urandom_range(0, 3)) stream_q.push_back(rand_byte());
    end else if (mode < 38) begin
      cut = $urandom_range(1, stream_q.size());
      while (stream_q.size() > cut) void'(stream_q.pop_back());
    end
  endtask

  initial begin
    int          target;
    logic [31:0] skip;
    target = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed opening with the reset setting of no skipped bytes.
    foreach (DIRECTED_SEQ[i]) send_byte(DIRECTED_SEQ[i][7:0], DIRECTED_SEQ[i][8]);

    for (int p = 0; p < 6; p++) begin
      skip = (p == 5) ? 32'($urandom_range(2, 9)) : SKIP_PLAN[p];
      write_skip(skip);
      // A stream that ends on the very byte that completes the skip is a clean end.
      if (p == 1) begin
        send_byte(rand_byte(), 1'b0);
        send_byte(rand_byte(), 1'b0);
        send_byte(rand_byte(), 1'b1);
      end
      target += BUDGET_PLAN[p];
      while (bytes_sent < target) begin
        build_stream(skip);
        foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
      end
    end

    drain();
    if (runs_sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
